>>> hdl/mplm_pkg.sv
package mplm_pkg;

    localparam int DEF_MAX_CHANNELS    = 8;
    localparam int DEF_LEVEL_FRAC_BITS = 16;

    // sample format codes
    localparam logic [2:0] FMT_U8  = 3'd0;
    localparam logic [2:0] FMT_U16 = 3'd1;
    localparam logic [2:0] FMT_U32 = 3'd2;
    localparam logic [2:0] FMT_S8  = 3'd3;
    localparam logic [2:0] FMT_S16 = 3'd4;
    localparam logic [2:0] FMT_S32 = 3'd5;

    // register indexes
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [2:0] FORMAT_RESET = FMT_S16;
    localparam logic [3:0] COUNT_RESET  = 4'd2;

    localparam logic [31:0] CHAR_FULL  = 32'd127;
    localparam logic [31:0] SHRT_FULL  = 32'd32767;
    localparam logic [31:0] INT_FULL   = 32'd2147483647;
    localparam logic [31:0] UCHAR_FULL = 32'd255;
    localparam logic [31:0] USHRT_FULL = 32'd65535;
    localparam logic [31:0] UINT_FULL  = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic load;
        logic prep;
        logic step;
    } t_dp_cmd;

    function automatic logic [31:0] full_of(input logic [2:0] fmt);
        logic [31:0] f;
        case (fmt)
            FMT_U8:  f = UCHAR_FULL;
            FMT_U16: f = USHRT_FULL;
            FMT_U32: f = UINT_FULL;
            FMT_S8:  f = CHAR_FULL;
            FMT_S16: f = SHRT_FULL;
            FMT_S32: f = INT_FULL;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

>>> hdl/mplm_ctrl.sv
module mplm_ctrl #(
    parameter int MAX_CHANNELS    = 8,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_CHANNELS+1)-1:0]      i_n,
    input  logic                                   i_s_tvalid,
    input  logic                                   i_s_tlast,
    input  logic                                   i_m_tready,
    output logic                                   o_s_tready,
    output logic                                   o_m_tvalid,
    output logic                                   o_m_tlast,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] o_k,
    output mplm_pkg::t_dp_cmd                      o_cmd
);
    import mplm_pkg::*;

    localparam int PW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    // fold steps needed until the remainder drops below the full scale
    localparam int FOLDS = (LEVEL_FRAC_BITS + 1) / 7 + 2;
    localparam int SW    = $clog2(FOLDS + 1);

    t_state        r_state, n_state;
    logic [PW-1:0] r_k;
    logic [SW-1:0] r_step;
    logic          last_ch;
    logic          step_done;

    assign last_ch   = (32'(r_k) + 32'd1) == 32'(i_n);
    assign step_done = r_step == SW'(FOLDS - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_s_tlast) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (step_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) n_state = last_ch ? S_IDLE : S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_LOAD: o_cmd.load = 1'b1;
            S_PREP: o_cmd.prep = 1'b1;
            S_DIV:  o_cmd.step = 1'b1;
            S_OUT:  o_m_tvalid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    assign o_m_tlast = last_ch;
    assign o_k       = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) r_k <= '0;
            else if (r_state == S_OUT && i_m_tready) r_k <= r_k + PW'(1);
            if (r_state == S_DIV) r_step <= r_step + SW'(1);
            else r_step <= '0;
        end
    end

endmodule

>>> hdl/mplm_dpath.sv
module mplm_dpath #(
    parameter int MAX_CHANNELS    = 8,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mplm_pkg::t_dp_cmd                      i_cmd,
    input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] i_k,
    input  logic [2:0]                             i_fmt,
    input  logic [$clog2(MAX_CHANNELS+1)-1:0]      i_n,
    input  logic [31:0]                            i_sample,
    input  logic                                   i_last,
    output logic [2:0]                             o_index,
    output logic [LEVEL_FRAC_BITS:0]               o_level
);
    import mplm_pkg::*;

    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int F  = LEVEL_FRAC_BITS;
    localparam int QW = F + 2;       // quotient bits
    localparam int NW = F + 34;      // halved scaled numerator

    logic [31:0]   r_peak [MAX_CHANNELS];
    logic [PW-1:0] r_pos;
    logic [NW-1:0] r_s;
    logic [QW-1:0] r_q;
    logic [2:0]    r_lfmt;
    logic          r_sat;
    logic          r_ok;

    logic [31:0]   mag;
    logic [7:0]    b8;
    logic [15:0]   b16;
    logic [PW-1:0] cur_pos;
    logic [PW-1:0] nxt_pos;
    logic [31:0]   pos_inc;

    logic [31:0]   p;
    logic [31:0]   full;
    logic [32:0]   two_p;
    logic [32:0]   num;
    logic [NW-1:0] scaled;
    logic [NW-1:0] fold_h;
    logic [NW-1:0] fold_l;
    logic [31:0]   lfull;
    logic [QW-1:0] q_fix;
    logic [31:0]   k_ext;

    always_comb begin
        b8  = i_sample[7:0];
        b16 = i_sample[15:0];
        case (i_fmt)
            FMT_U8:  mag = {24'd0, b8};
            FMT_U16: mag = {16'd0, b16};
            FMT_U32: mag = i_sample;
            FMT_S8:  mag = {24'd0, b8[7] ? (~b8 + 8'd1) : b8};
            FMT_S16: mag = {16'd0, b16[15] ? (~b16 + 16'd1) : b16};
            FMT_S32: mag = i_sample[31] ? (~i_sample + 32'd1) : i_sample;
            default: mag = 32'd0;
        endcase
    end

    // a counter left past a shrunk channel count restarts at channel 0
    assign cur_pos = (32'(r_pos) < 32'(i_n)) ? r_pos : '0;
    assign pos_inc = 32'(cur_pos) + 32'd1;
    assign nxt_pos = (pos_inc >= 32'(i_n)) ? '0 : PW'(pos_inc);

    // level = (num * 2^F + full/2) / full, full = 2^m - 1
    always_comb begin
        p      = r_peak[i_k];
        full   = full_of(i_fmt);
        two_p  = {p, 1'b0};
        if (i_fmt <= FMT_U32) begin
            num = (two_p >= {1'b0, full}) ? (two_p - {1'b0, full})
                                          : ({1'b0, full} - two_p);
        end else begin
            num = {1'b0, p};
        end
        scaled = (NW'(num) << F) + NW'(full >> 1);
    end

    // s = h * 2^m + l = h * full + (h + l), so h goes to the quotient
    always_comb begin
        case (r_lfmt)
            FMT_U8: begin
                fold_h = r_s >> 8;
                fold_l = NW'(r_s[7:0]);
            end
            FMT_U16: begin
                fold_h = r_s >> 16;
                fold_l = NW'(r_s[15:0]);
            end
            FMT_U32: begin
                fold_h = r_s >> 32;
                fold_l = NW'(r_s[31:0]);
            end
            FMT_S8: begin
                fold_h = r_s >> 7;
                fold_l = NW'(r_s[6:0]);
            end
            FMT_S16: begin
                fold_h = r_s >> 15;
                fold_l = NW'(r_s[14:0]);
            end
            FMT_S32: begin
                fold_h = r_s >> 31;
                fold_l = NW'(r_s[30:0]);
            end
            default: begin
                fold_h = '0;
                fold_l = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) r_peak[i] <= 32'd0;
            r_pos <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (mag > r_peak[cur_pos]) r_peak[cur_pos] <= mag;
                r_pos <= i_last ? '0 : nxt_pos;
            end
            if (i_cmd.load) r_peak[i_k] <= 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s    <= scaled;
            r_q    <= '0;
            r_lfmt <= i_fmt;
            r_ok   <= i_fmt <= FMT_S32;
        end
        if (i_cmd.prep) begin
            // quotient would not fit in F+1 bits
            r_sat <= fold_h[NW-1:F+1] != '0;
        end
        if (i_cmd.step) begin
            r_q <= r_q + fold_h[QW-1:0];
            r_s <= fold_h + fold_l;
        end
    end

    // a remainder equal to full scale still holds one more unit
    assign lfull = full_of(r_lfmt);
    assign q_fix = r_q + ((r_s == NW'(lfull)) ? QW'(1) : QW'(0));

    always_comb begin
        if (!r_ok) o_level = '0;
        else if (r_sat || q_fix[QW-1]) o_level = '1;
        else o_level = q_fix[F:0];
    end

    assign k_ext   = 32'(i_k);
    assign o_index = k_ext[2:0];

endmodule

>>> hdl/multichannel_peak_level_meter.sv
// channel   dir  payload                                     handshake
// s_*       in   tdata[31:0] sample_bits, tlast buffer_end   tvalid/tready
// m_*       out  tdata channel_index, level; tlast last_level tvalid/tready
// apb       in   sample_format @0x0, channel_count @0x4      psel/penable, pready=1
//
// a sample without tlast leaves s_tready high; the next one is taken right after
// a sample with tlast is followed by a burst of n levels, each going through load,
// saturation check, fold steps dividing by the full scale and output, which waits
// while m_tready is low
// s_tready is low for the whole burst; peaks are cleared as they are read
// synchronous active-low reset clears the peaks and the channel counter
module multichannel_peak_level_meter #(
    parameter int MAX_CHANNELS    = mplm_pkg::DEF_MAX_CHANNELS,
    parameter int LEVEL_FRAC_BITS = mplm_pkg::DEF_LEVEL_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] sample_bits
    input  logic        s_tlast,  // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] channel_index, [LEVEL_FRAC_BITS+3:3] level, zero fill above
    output logic [((LEVEL_FRAC_BITS + 11) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tlast,  // last_level
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mplm_pkg::*;

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int LW = LEVEL_FRAC_BITS + 1;
    localparam int OW = ((LEVEL_FRAC_BITS + 11) / 8) * 8;

    logic [2:0]    r_fmt;
    logic [3:0]    r_count;
    logic [CW-1:0] n_act;
    logic          wr_en;
    t_dp_cmd       cmd;
    logic [PW-1:0] k;
    logic [2:0]    index;
    logic [LW-1:0] level;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FORMAT_RESET;
            r_count <= COUNT_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_FORMAT) r_fmt <= pwdata[2:0];
            else r_count <= pwdata[3:0];
        end
    end

    assign prdata = (paddr[2] == REG_COUNT) ? {28'd0, r_count} : {29'd0, r_fmt};

    always_comb begin
        if (r_count == 4'd0) n_act = CW'(1);
        else if (32'(r_count) > MAX_CHANNELS) n_act = CW'(MAX_CHANNELS);
        else n_act = CW'(r_count);
    end

    mplm_ctrl #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_n       (n_act),
        .i_s_tvalid(s_tvalid),
        .i_s_tlast (s_tlast),
        .i_m_tready(m_tready),
        .o_s_tready(s_tready),
        .o_m_tvalid(m_tvalid),
        .o_m_tlast (m_tlast),
        .o_k       (k),
        .o_cmd     (cmd)
    );

    mplm_dpath #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_k     (k),
        .i_fmt   (r_fmt),
        .i_n     (n_act),
        .i_sample(s_tdata),
        .i_last  (s_tlast),
        .o_index (index),
        .o_level (level)
    );

    assign m_tdata = OW'({level, index});

endmodule

>>> hdl/mplm_checker.sv
module mplm_checker #(
    parameter int LEVEL_FRAC_BITS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic i_s_tready,
    input logic i_s_tlast,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [((LEVEL_FRAC_BITS + 11) / 8) * 8 - 1:0] i_m_tdata,
    input logic i_m_tlast
);

    // a held level must not change while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
                                      && $stable(i_m_tlast))
        else $error("output item changed under stall");

    // samples and levels never move in the same cycle
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_tready && i_m_tvalid))
        else $error("input ready during level burst");

    // a sample that does not end a buffer leaves the input open
    a_plain_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready && !i_s_tlast |=> i_s_tready)
        else $error("input stalled after plain sample");

    // the last level of a burst reopens the input
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && i_m_tlast |=> i_s_tready && !i_m_tvalid)
        else $error("burst did not end after last level");

    // inner levels of a burst are followed by a gap while the next one is computed
    a_burst_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && !i_m_tlast |=> !i_m_tvalid && !i_s_tready)
        else $error("burst broke off early");

endmodule

bind multichannel_peak_level_meter mplm_checker #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
) u_mplm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(s_tvalid),
    .i_s_tready(s_tready),
    .i_s_tlast (s_tlast),
    .i_m_tvalid(m_tvalid),
    .i_m_tready(m_tready),
    .i_m_tdata (m_tdata),
    .i_m_tlast (m_tlast)
);

>>> dv/multichannel_peak_level_meter_test.sv
`timescale 1ns / 1ps

module multichannel_peak_level_meter_test;
    import mplm_pkg::*;

    localparam int MAX_CH   = DEF_MAX_CHANNELS;
    localparam int FRAC     = DEF_LEVEL_FRAC_BITS;
    localparam int LEVEL_W  = FRAC + 1;
    localparam int M_DATA_W = ((FRAC + 11) / 8) * 8;
    localparam int RANDOM_ITEMS = 300;

    typedef struct {
        logic [2:0]         channel_index;
        logic [LEVEL_W-1:0] level;
        logic               last_level;
    } t_level_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    logic [2:0]    fmt_setting;
    logic [3:0]    count_setting;
    logic [31:0]   peak_store [MAX_CH];
    int            scan_position;
    t_level_result level_queue [$];
    int            error_count;
    bit            pacing_on;
    int            stall_left;

    multichannel_peak_level_meter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int active_channels();
        if (count_setting == 4'd0) begin
            return 1;
        end
        if (count_setting > MAX_CH) begin
            return MAX_CH;
        end
        return int'(count_setting);
    endfunction

    function automatic logic [31:0] magnitude_of(input logic [2:0] fmt, input logic [31:0] x);
        logic [31:0] b;
        case (fmt)
            FMT_U8:  return {24'd0, x[7:0]};
            FMT_U16: return {16'd0, x[15:0]};
            FMT_U32: return x;
            FMT_S8: begin
                b = {24'd0, x[7:0]};
                return b[7] ? 32'h100 - b : b;
            end
            FMT_S16: begin
                b = {16'd0, x[15:0]};
                return b[15] ? 32'h1_0000 - b : b;
            end
            FMT_S32: return x[31] ? ~x + 32'd1 : x;
            default: return 32'd0;
        endcase
    endfunction

    // rounded peak / full scale (|2*peak - full| for unsigned) in unsigned q1.16, saturated
    function automatic logic [LEVEL_W-1:0] level_for(input logic [2:0] fmt,
                                                     input logic [31:0] peak);
        logic [63:0] full;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] twice;
        case (fmt)
            FMT_U8:  full = 64'(UCHAR_FULL);
            FMT_U16: full = 64'(USHRT_FULL);
            FMT_U32: full = 64'(UINT_FULL);
            FMT_S8:  full = 64'(CHAR_FULL);
            FMT_S16: full = 64'(SHRT_FULL);
            FMT_S32: full = 64'(INT_FULL);
            default: return '0;
        endcase
        twice = 64'(peak) << 1;
        if (fmt <= FMT_U32) begin
            // distance from mid-scale
            num = (twice >= full) ? twice - full : full - twice;
        end else begin
            num = 64'(peak);
        end
        q = ((num << (FRAC + 1)) + full) / (full << 1);
        if (q > {LEVEL_W{1'b1}}) begin
            q = {LEVEL_W{1'b1}};
        end
        return q[LEVEL_W-1:0];
    endfunction

    task automatic meter_accept_sample(input logic [31:0] sample, input logic buffer_end);
        int n;
        int pos;
        logic [31:0] mag;
        t_level_result r;
        n   = active_channels();
        pos = (scan_position < n) ? scan_position : 0;
        mag = magnitude_of(fmt_setting, sample);
        if (mag > peak_store[pos]) begin
            peak_store[pos] = mag;
        end
        pos++;
        scan_position = (pos >= n) ? 0 : pos;
        if (buffer_end) begin
            for (int k = 0; k < n; k++) begin
                r.channel_index = k[2:0];
                r.level         = level_for(fmt_setting, peak_store[k]);
                r.last_level    = (k + 1 == n);
                level_queue.push_back(r);
                peak_store[k] = '0;
            end
            scan_position = 0;
        end
    endtask

    function automatic int gap_cycles();
        int r;
        if (!pacing_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(input logic [31:0] sample, input logic buffer_end);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            s_tdata  = $urandom;
            s_tlast  = 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = sample;
        s_tlast  = buffer_end;
        do @(posedge i_clk); while (!s_tready);
        meter_accept_sample(sample, buffer_end);
    endtask

    // hold the sender until every level has come out and the block has settled
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (level_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic reg_index, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {reg_index, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_index == REG_FORMAT) begin
            fmt_setting = value[2:0];
        end else begin
            count_setting = value[3:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(input logic [2:0] fmt, input logic [3:0] count);
        wait_drained();
        reg_write(REG_FORMAT, {29'd0, fmt});
        reg_write(REG_COUNT, {28'd0, count});
    endtask

    task automatic test_reset_defaults();
        // s16, two channels; the most negative code reads slightly above 1.0
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'hFFFF_7FFF, 1'b1);
    endtask

    task automatic test_format_extremes();
        logic [2:0] fmt;
        for (int f = 0; f < 6; f++) begin
            fmt = f[2:0];
            set_config(fmt, 4'd2);
            if (fmt <= FMT_U32) begin
                // channel 1 keeps peak 0, which is full distance from mid-scale
                send_sample(32'hFFFF_FFFF, 1'b0);
                send_sample(32'h0000_0000, 1'b1);
            end else begin
                send_sample(32'h8000_8080, 1'b0);
                send_sample(32'h7FFF_7F7F, 1'b1);
            end
        end
    endtask

    task automatic test_undefined_formats();
        set_config(3'd6, 4'd3);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        set_config(3'd7, 4'd3);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
    endtask

    task automatic test_count_limits();
        // zero acts as one channel, above the maximum acts as the maximum
        set_config(FMT_S8, 4'd0);
        send_sample(32'h0000_0080, 1'b1);
        set_config(FMT_S32, 4'd15);
        send_sample(32'h8000_0000, 1'b1);
    endtask

    task automatic test_mid_buffer_changes();
        set_config(FMT_S16, 4'd6);
        send_sample(32'h0000_8000, 1'b0);
        send_sample(32'h0000_1234, 1'b0);
        send_sample(32'h0000_7FFF, 1'b0);
        send_sample(32'h0000_C000, 1'b0);
        // counter sits at 4, past the new count, so the next item lands on channel 0
        set_config(FMT_U8, 4'd2);
        send_sample(32'h0000_00F0, 1'b1);
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return {16'($urandom_range(0, 65535)), 16'h8000};
            5:       return {16'($urandom_range(0, 65535)), 16'h7FFF};
            6:       return {24'($urandom_range(0, 16777215)), 8'h80};
            7:       return {24'($urandom_range(0, 16777215)), 8'h7F};
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random_buffers();
        int sent;
        int len;
        int n;
        logic [2:0] fmt;
        logic [3:0] count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            fmt   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            count = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(1, 8));
            if ($urandom_range(0, 9) == 0) begin
                count = 4'd0;
            end
            set_config(fmt, count);
            pacing_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) begin
                n   = active_channels();
                len = $urandom_range(1, 3 * n);
                for (int k = 0; k < len; k++) begin
                    if (len > 2 && k == len / 2 && $urandom_range(0, 5) == 0) begin
                        wait_drained();
                        reg_write(REG_COUNT, $urandom_range(0, 15));
                    end
                    send_sample(random_sample(), k == len - 1);
                    sent++;
                end
            end
        end
        pacing_on = 1'b1;
    endtask

    // receiver stalls: mostly short, now and then long
    initial begin : drive_ready
        int roll;
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (pacing_on) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 15) begin
                        stall_left = $urandom_range(1, 3);
                    end else if (roll < 18) begin
                        stall_left = $urandom_range(10, 40);
                    end else begin
                        stall_left = 0;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_levels
        t_level_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (level_queue.size() == 0) begin
                $error("level item with none expected: channel_index %0d level %0d",
                       m_tdata[2:0], m_tdata[FRAC+3:3]);
                error_count++;
            end else begin
                want = level_queue.pop_front();
                if (m_tdata[2:0] !== want.channel_index) begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[FRAC+3:3] !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, m_tdata[FRAC+3:3]);
                    error_count++;
                end
                if (m_tlast !== want.last_level) begin
                    $error("last_level: expected %0d, got %0d", want.last_level, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("multichannel_peak_level_meter: mismatch");
        $finish;
    end

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count   = 0;
        pacing_on     = 1'b1;
        fmt_setting   = FORMAT_RESET;
        count_setting = COUNT_RESET;
        scan_position = 0;
        for (int c = 0; c < MAX_CH; c++) begin
            peak_store[c] = '0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_format_extremes();
        test_undefined_formats();
        test_count_limits();
        test_mid_buffer_changes();
        test_random_buffers();

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("multichannel_peak_level_meter: match");
        end else begin
            $display("multichannel_peak_level_meter: mismatch");
        end
        $finish;
    end

endmodule
